// ===== rtl/pkst_pkg.sv =====
// Package: shared types, constants and codes of the peer keepalive and sync tracker.
`default_nettype none
package pkst_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int NUM_W = 49;
    localparam int MAG_W = 48;
    localparam int DEN_W = 16;
    localparam int QUO_W = 32;
    localparam int WORK_W = 50;

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
    localparam logic [15:0] SAT16 = 16'hFFFF;

    localparam logic [15:0] RST_SYNC_DELAY = 16'd1000;
    localparam logic [15:0] RST_CHECK_SEND = 16'd1000;
    localparam logic [15:0] RST_CHECK_RESEND = 16'd500;
    localparam logic [15:0] RST_REPLY_DELAY = 16'd1000;
    localparam logic [15:0] RST_MAX_UNANSWERED = 16'd5;
    localparam logic [15:0] RST_REPLIES_TO_SYNC = 16'd3;
    localparam logic [31:0] RST_MAX_UNIX_DIFF = 32'd1000;

    typedef enum logic [3:0] {
        CMD_TICK      = 4'd0,
        CMD_RECEIVED  = 4'd1,
        CMD_RESENT    = 4'd2,
        CMD_SYNCSENT  = 4'd3,
        CMD_REPLYSENT = 4'd4,
        CMD_SYNCREPLY = 4'd5,
        CMD_RESYNC    = 4'd6,
        CMD_PING      = 4'd7,
        CMD_SETDIFF   = 4'd8,
        CMD_CHECK     = 4'd9,
        CMD_SETFLAG   = 4'd10
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SYNC_DELAY      = 3'd0,
        REG_CHECK_SEND      = 3'd1,
        REG_CHECK_RESEND    = 3'd2,
        REG_REPLY_DELAY     = 3'd3,
        REG_MAX_UNANSWERED  = 3'd4,
        REG_REPLIES_TO_SYNC = 3'd5,
        REG_MAX_UNIX_DIFF   = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_NUM,
        S_START,
        S_DIV,
        S_PING,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] sync_delay;
        logic [15:0] check_send;
        logic [15:0] check_resend;
        logic [15:0] reply_delay;
        logic [15:0] max_unanswered;
        logic [15:0] replies_to_sync;
        logic [31:0] max_unix_diff;
    } cfg_t;

    typedef struct packed {
        logic [31:0] until_sync_request;
        logic [31:0] until_check_request;
        logic [31:0] until_check_reply;
        logic        active;
        logic        connected;
        logic        synced;
        logic        ping_known;
        logic [30:0] ping;
        logic [31:0] offset_mean;
        logic        resync_required;
        logic        in_unsynced_list;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/pkst_if.sv =====
// Interfaces: the event input channel and the result output channel.
`default_nettype none
interface pkst_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] time_offset;
    logic signed [31:0] remote_time;
    logic [47:0]        unix_time;
    logic signed [47:0] unix_difference;
    logic               unsynced_flag;

    modport source (
        output valid, command, time_offset, remote_time, unix_time,
               unix_difference, unsynced_flag,
        input  ready
    );
    modport sink (
        input  valid, command, time_offset, remote_time, unix_time,
               unix_difference, unsynced_flag,
        output ready
    );
endinterface

interface pkst_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] until_sync_request;
    logic signed [31:0] until_check_request;
    logic signed [31:0] until_check_reply;
    logic               active;
    logic               connected;
    logic               synced;
    logic               ping_known;
    logic [30:0]        ping;
    logic signed [31:0] offset_mean;
    logic               resync_required;
    logic               in_unsynced_list;

    modport source (
        output valid, until_sync_request, until_check_request, until_check_reply,
               active, connected, synced, ping_known, ping, offset_mean,
               resync_required, in_unsynced_list,
        input  ready
    );
    modport sink (
        input  valid, until_sync_request, until_check_request, until_check_reply,
               active, connected, synced, ping_known, ping, offset_mean,
               resync_required, in_unsynced_list,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/pkst_regs.sv =====
// Configuration register bank behind the APB-style port.
`default_nettype none
module pkst_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pkst_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [pkst_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [pkst_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output pkst_pkg::cfg_t                        cfg
);
    import pkst_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_delay      <= RST_SYNC_DELAY;
            cfg_reg.check_send      <= RST_CHECK_SEND;
            cfg_reg.check_resend    <= RST_CHECK_RESEND;
            cfg_reg.reply_delay     <= RST_REPLY_DELAY;
            cfg_reg.max_unanswered  <= RST_MAX_UNANSWERED;
            cfg_reg.replies_to_sync <= RST_REPLIES_TO_SYNC;
            cfg_reg.max_unix_diff   <= RST_MAX_UNIX_DIFF;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SYNC_DELAY:      cfg_reg.sync_delay      <= pwdata[15:0];
                REG_CHECK_SEND:      cfg_reg.check_send      <= pwdata[15:0];
                REG_CHECK_RESEND:    cfg_reg.check_resend    <= pwdata[15:0];
                REG_REPLY_DELAY:     cfg_reg.reply_delay     <= pwdata[15:0];
                REG_MAX_UNANSWERED:  cfg_reg.max_unanswered  <= pwdata[15:0];
                REG_REPLIES_TO_SYNC: cfg_reg.replies_to_sync <= pwdata[15:0];
                REG_MAX_UNIX_DIFF:   cfg_reg.max_unix_diff   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SYNC_DELAY:      prdata = {16'b0, cfg_reg.sync_delay};
            REG_CHECK_SEND:      prdata = {16'b0, cfg_reg.check_send};
            REG_CHECK_RESEND:    prdata = {16'b0, cfg_reg.check_resend};
            REG_REPLY_DELAY:     prdata = {16'b0, cfg_reg.reply_delay};
            REG_MAX_UNANSWERED:  prdata = {16'b0, cfg_reg.max_unanswered};
            REG_REPLIES_TO_SYNC: prdata = {16'b0, cfg_reg.replies_to_sync};
            REG_MAX_UNIX_DIFF:   prdata = cfg_reg.max_unix_diff;
            default:             prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/pkst_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module pkst_div (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [pkst_pkg::NUM_W-1:0]    num,
    input  wire logic        [pkst_pkg::DEN_W-1:0]    den,
    output logic                                      busy,
    output logic                                      done,
    output logic signed      [pkst_pkg::QUO_W-1:0]    quo
);
    import pkst_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;

    assign mag     = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign trial   = {1'b0, shifted} - {2'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = mag[MAG_W-1:0];
            den_next  = den;
            neg_next  = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[MAG_W-2:0], ~trial[DEN_W+1]};
            rem_next = trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? (QUO_W'(0) - quo_reg[QUO_W-1:0]) : quo_reg[QUO_W-1:0];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a preceding run");
    a_first_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == '0) |-> $past(start))
        else $error("divider step count out of sequence");
`endif

endmodule
`default_nettype wire

// ===== rtl/peer_keepalive_sync_tracker_unit.sv =====
// Top level: event sequencer and peer state of the keepalive and sync tracker.
//
// Channel   Direction  Transfer condition          Contents
// in_ch     sink       valid and ready high        one event with its fields
// out_ch    source     valid and ready high        one result per event
// APB       slave      psel, penable, pwrite high  configuration registers
//
// An event is taken only in the idle state and yields one result transfer.
// Most events go from S_EXEC straight to S_DONE; a ping update with sync
// replies counted passes S_PING, the resync check S_CHECK, and a sync reply
// S_MUL, S_NUM, S_START and S_DIV, where it waits for the 48-step divider.
// The result waits in an output register; a stall there holds the sequencer.
// Reset clears all peer state and loads the register defaults.
`default_nettype none
module peer_keepalive_sync_tracker_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pkst_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [pkst_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [pkst_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    pkst_in_if.sink                               in_ch,
    pkst_out_if.source                            out_ch
);
    import pkst_pkg::*;

    cfg_t cfg;

    state_t state_reg, state_next;

    cmd_t               cmd_reg;
    logic signed [31:0] offset_reg;
    logic signed [31:0] remote_reg;
    logic [47:0]        unix_reg;
    logic signed [47:0] udiff_reg;
    logic               flag_reg;

    logic [31:0]        now_reg, now_next;
    logic [30:0]        since_sync_reg, since_sync_next;
    logic [15:0]        cur_sync_reg, cur_sync_next;
    logic [30:0]        since_chk_reg, since_chk_next;
    logic [15:0]        cur_chk_reg, cur_chk_next;
    logic [30:0]        since_rep_reg, since_rep_next;
    logic [15:0]        unans_reg, unans_next;
    logic               ever_reg, ever_next;
    logic               mark_reg, mark_next;
    logic signed [31:0] mean_reg, mean_next;
    logic [15:0]        rcount_reg, rcount_next;
    logic [30:0]        ping_reg, ping_next;
    logic               ping_valid_reg, ping_valid_next;
    logic signed [47:0] stored_diff_reg, stored_diff_next;
    logic               resync_reg, resync_next;
    logic [WORK_W-1:0]  work_reg, work_next;

    res_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;

    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic signed [QUO_W-1:0]  div_quo;

    logic [15:0]        nm1;
    logic signed [48:0] prod;
    logic [WORK_W-1:0]  pdiff;
    logic [WORK_W-1:0]  absd;
    logic               accept;
    logic               active;

    pkst_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pkst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (work_reg[NUM_W-1:0]),
        .den   (rcount_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign nm1    = rcount_reg - 16'd1;
    assign prod   = $signed({1'b0, nm1}) * mean_reg;
    assign pdiff  = {18'b0, now_reg} - work_reg;
    assign absd   = work_reg[WORK_W-1] ? (WORK_W'(0) - work_reg) : work_reg;
    assign active = (unans_reg <= cfg.max_unanswered);

    always_comb
    begin
        state_next       = state_reg;
        now_next         = now_reg;
        since_sync_next  = since_sync_reg;
        cur_sync_next    = cur_sync_reg;
        since_chk_next   = since_chk_reg;
        cur_chk_next     = cur_chk_reg;
        since_rep_next   = since_rep_reg;
        unans_next       = unans_reg;
        ever_next        = ever_reg;
        mark_next        = mark_reg;
        mean_next        = mean_reg;
        rcount_next      = rcount_reg;
        ping_next        = ping_reg;
        ping_valid_next  = ping_valid_reg;
        stored_diff_next = stored_diff_reg;
        resync_next      = resync_reg;
        work_next        = work_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        div_start        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    resync_next = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        now_next        = now_reg + 32'd1;
                        since_sync_next = (since_sync_reg == SAT31) ? SAT31
                                          : since_sync_reg + 31'd1;
                        since_chk_next  = (since_chk_reg == SAT31) ? SAT31
                                          : since_chk_reg + 31'd1;
                        since_rep_next  = (since_rep_reg == SAT31) ? SAT31
                                          : since_rep_reg + 31'd1;
                    end
                    CMD_RECEIVED:
                    begin
                        since_chk_next = '0;
                        cur_chk_next   = cfg.check_send;
                        unans_next     = '0;
                        ever_next      = 1'b1;
                    end
                    CMD_RESENT:
                    begin
                        since_chk_next = '0;
                        cur_chk_next   = cfg.check_resend;
                        if (unans_reg != SAT16)
                        begin
                            unans_next = unans_reg + 16'd1;
                        end
                    end
                    CMD_SYNCSENT:
                    begin
                        since_sync_next = '0;
                        cur_sync_next   = cfg.sync_delay;
                    end
                    CMD_REPLYSENT:
                    begin
                        since_rep_next = '0;
                    end
                    CMD_SYNCREPLY:
                    begin
                        if (rcount_reg != SAT16)
                        begin
                            rcount_next = rcount_reg + 16'd1;
                        end
                        state_next = S_MUL;
                    end
                    CMD_RESYNC:
                    begin
                        ping_valid_next = 1'b0;
                        ping_next       = '0;
                        rcount_next     = '0;
                    end
                    CMD_PING:
                    begin
                        if (rcount_reg != 16'd0)
                        begin
                            work_next  = {{18{remote_reg[31]}}, remote_reg}
                                       + {{18{mean_reg[31]}}, mean_reg};
                            state_next = S_PING;
                        end
                    end
                    CMD_SETDIFF:
                    begin
                        stored_diff_next = udiff_reg;
                    end
                    CMD_CHECK:
                    begin
                        work_next  = {{2{stored_diff_reg[47]}}, stored_diff_reg}
                                   - {2'b0, unix_reg};
                        state_next = S_CHECK;
                    end
                    CMD_SETFLAG:
                    begin
                        mark_next = flag_reg;
                    end
                    default: ;
                endcase
            end
            S_MUL:
            begin
                work_next  = {prod[48], prod};
                state_next = S_NUM;
            end
            S_NUM:
            begin
                work_next  = work_reg + {{18{offset_reg[31]}}, offset_reg};
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo;
                    state_next = S_DONE;
                end
            end
            S_PING:
            begin
                if (pdiff[WORK_W-1])
                begin
                    ping_next = '0;
                end
                else if (|pdiff[WORK_W-2:31])
                begin
                    ping_next = SAT31;
                end
                else
                begin
                    ping_next = pdiff[30:0];
                end
                ping_valid_next = 1'b1;
                state_next      = S_DONE;
            end
            S_CHECK:
            begin
                resync_next = (rcount_reg != 16'd0) && (absd > {18'b0, cfg.max_unix_diff});
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    res_next.until_sync_request  = {16'b0, cur_sync_reg}
                                                 - {1'b0, since_sync_reg};
                    res_next.until_check_request = {16'b0, cur_chk_reg}
                                                 - {1'b0, since_chk_reg};
                    res_next.until_check_reply   = {16'b0, cfg.reply_delay}
                                                 - {1'b0, since_rep_reg};
                    res_next.active              = active;
                    res_next.connected           = active && ever_reg;
                    res_next.synced              = (rcount_reg >= cfg.replies_to_sync);
                    res_next.ping_known          = ping_valid_reg;
                    res_next.ping                = ping_valid_reg ? ping_reg : '0;
                    res_next.offset_mean         = mean_reg;
                    res_next.resync_required     = resync_reg;
                    res_next.in_unsynced_list    = mark_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            now_reg         <= '0;
            since_sync_reg  <= '0;
            cur_sync_reg    <= '0;
            since_chk_reg   <= '0;
            cur_chk_reg     <= '0;
            since_rep_reg   <= '0;
            unans_reg       <= '0;
            ever_reg        <= 1'b0;
            mark_reg        <= 1'b0;
            mean_reg        <= '0;
            rcount_reg      <= '0;
            ping_reg        <= '0;
            ping_valid_reg  <= 1'b0;
            stored_diff_reg <= '0;
            resync_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            now_reg         <= now_next;
            since_sync_reg  <= since_sync_next;
            cur_sync_reg    <= cur_sync_next;
            since_chk_reg   <= since_chk_next;
            cur_chk_reg     <= cur_chk_next;
            since_rep_reg   <= since_rep_next;
            unans_reg       <= unans_next;
            ever_reg        <= ever_next;
            mark_reg        <= mark_next;
            mean_reg        <= mean_next;
            rcount_reg      <= rcount_next;
            ping_reg        <= ping_next;
            ping_valid_reg  <= ping_valid_next;
            stored_diff_reg <= stored_diff_next;
            resync_reg      <= resync_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        res_reg  <= res_next;
        if (accept)
        begin
            cmd_reg    <= cmd_t'(in_ch.command);
            offset_reg <= in_ch.time_offset;
            remote_reg <= in_ch.remote_time;
            unix_reg   <= in_ch.unix_time;
            udiff_reg  <= in_ch.unix_difference;
            flag_reg   <= in_ch.unsynced_flag;
        end
    end

    assign out_ch.valid               = out_valid_reg;
    assign out_ch.until_sync_request  = res_reg.until_sync_request;
    assign out_ch.until_check_request = res_reg.until_check_request;
    assign out_ch.until_check_reply   = res_reg.until_check_reply;
    assign out_ch.active              = res_reg.active;
    assign out_ch.connected           = res_reg.connected;
    assign out_ch.synced              = res_reg.synced;
    assign out_ch.ping_known          = res_reg.ping_known;
    assign out_ch.ping                = res_reg.ping;
    assign out_ch.offset_mean         = res_reg.offset_mean;
    assign out_ch.resync_required     = res_reg.resync_required;
    assign out_ch.in_unsynced_list    = res_reg.in_unsynced_list;

`ifndef SYNTHESIS
    a_ping_needs_replies: assert property (@(posedge clk) disable iff (!rst_n)
        ping_valid_reg |-> (rcount_reg != 16'd0))
        else $error("ping marked known with no sync replies counted");
    a_mean_from_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (mean_reg != $past(mean_reg)) |-> $past(div_done))
        else $error("mean offset changed outside a divider completion");
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result transfer offered outside the done state");
    a_divider_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running while the sequencer is elsewhere");
`endif

endmodule
`default_nettype wire
